// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define LPS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// Implication checked at every clock edge out of reset
`define LPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lps_pkg.sv -----
package lps_pkg;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAW,
        ST_DIST,
        ST_SUM,
        ST_AVG,
        ST_PID,
        ST_KP,
        ST_KI,
        ST_KD,
        ST_CLAMP,
        ST_STEP,
        ST_OUT
    } t_state;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_KP         = 3'd0,
        REG_KI         = 3'd1,
        REG_KD         = 3'd2,
        REG_LEVEL_GOAL = 3'd3,
        REG_LEVEL_REF  = 3'd4,
        REG_OUT_MAX    = 3'd5,
        REG_STEP_BASE  = 3'd6,
        REG_STEP_GAIN  = 3'd7
    } t_reg_idx;

    localparam int DIV_W = 24;
    localparam int DSR_W = 14;
    localparam int MUL_W = 32;

    localparam logic [DSR_W-1:0] US_DIVISOR   = 14'd1000;
    localparam logic [DSR_W-1:0] CAL_DIVISOR  = 14'd9536;
    localparam logic [DIV_W-1:0] CAL_OFFSET   = 24'd4393;
    localparam logic [63:0]      KI_LIMIT     = 64'h4000_0000_0000_0000;
    localparam logic [23:0]      TOP24        = 24'hFF_FFFF;

endpackage

// ----- rtl/lps_mul.sv -----
module lps_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lps_pkg::MUL_W-1:0]  i_mcand,
    input  logic [lps_pkg::MUL_W-1:0]  i_mplier,
    output lps_pkg::t_unit_sts         o_sts,
    output logic [2*lps_pkg::MUL_W-1:0] o_prod
);

    localparam int W = lps_pkg::MUL_W;

    logic [W-1:0]   r_mcand;
    logic [2*W-1:0] r_prod;
    logic [$clog2(W)-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     w_sum;

    // Add the multiplicand into the upper half when the low multiplier bit is set
    assign w_sum = {1'b0, r_prod[2*W-1:W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);

    // Control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(W))'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the product right as bits retire
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_prod  <= {{W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[W-1:1]};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_prod;

endmodule

// ----- rtl/lps_div.sv -----
module lps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lps_pkg::DIV_W-1:0]  i_dividend,
    input  logic [lps_pkg::DSR_W-1:0]  i_divisor,
    output lps_pkg::t_unit_sts         o_sts,
    output logic [lps_pkg::DIV_W-1:0]  o_quo
);

    localparam int DW = lps_pkg::DIV_W;
    localparam int SW = lps_pkg::DSR_W;

    logic [DW-1:0]  r_quo;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_div;
    logic [$clog2(DW)-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [SW:0]    w_shift;
    logic [SW+1:0]  w_diff;

    // Trial subtract of the divisor from the shifted remainder
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b0, r_div};

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DW))'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ~w_diff[SW+1]};
            r_rem <= w_diff[SW+1] ? w_shift[SW-1:0] : w_diff[SW-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

// ----- rtl/level_pid_valve_stepper.sv -----
// Ultrasonic level loop driving a stepper valve. Each item on the slave stream is one
// echo pulse width in microseconds; it becomes a calibrated distance, enters a moving
// average over AVERAGE_DEPTH samples, and a Q8.24 PID step with a saturating integral
// and an output clamped to [0, out_max] sets a new valve step target. One result item
// per input item reports the level, controller output, target and the move from the
// previous position. Each item makes three passes of the bit-serial divider (echo
// scaling, calibration, average) and four passes of the bit-serial multiplier (three
// gains, step mapping), each pass being a start step, one bit per cycle and a done
// step, with sequencing states between the passes. When the echo scales to zero the
// calibration pass is skipped. The next item is accepted once the result is in the
// output register, so a result not yet taken stalls the input. Gains and limits are
// written over the APB port at byte address 4*index.
module level_pid_valve_stepper #(
    parameter int AVERAGE_DEPTH = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] echo_us
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] water_level, [42:12] pid_out, [66:43] step_target,
    // [90:67] step_count, [91] step_dir, [95:92] zero
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(AVERAGE_DEPTH);
    localparam int SUM_W = 11 + $clog2(AVERAGE_DEPTH);

    // Configuration registers
    logic [31:0] r_kp, r_ki, r_kd;
    logic [10:0] r_level_goal, r_level_ref;
    logic [30:0] r_out_max;
    logic [22:0] r_step_base;
    logic [19:0] r_step_gain;

    // Sequencer and datapath state
    lps_pkg::t_state r_state, n_state;
    logic            r_issued, n_issued;
    logic [20:0]     r_us17;
    logic [10:0]     r_raw;
    logic [10:0]     r_dist;
    logic [10:0]     r_ring [AVERAGE_DEPTH];
    logic [PTR_W-1:0] r_ptr;
    logic [SUM_W-1:0] r_sum;
    logic [11:0]     r_level;
    logic [12:0]     r_err;
    logic [12:0]     r_prev;
    logic [13:0]     r_deriv;
    logic [31:0]     r_int;
    logic [63:0]     r_acc;
    logic [30:0]     r_pid;
    logic [23:0]     r_target;
    logic [23:0]     r_pos;

    // Output register
    logic            r_mvalid;
    logic [11:0]     r_o_level;
    logic [30:0]     r_o_pid;
    logic [23:0]     r_o_target;
    logic [23:0]     r_o_count;
    logic            r_o_dir;

    // Unit hookup
    logic                       w_div_start, w_mul_start;
    logic [lps_pkg::DIV_W-1:0]  w_dividend, w_quo;
    logic [lps_pkg::DSR_W-1:0]  w_divisor;
    lps_pkg::t_unit_sts         w_div_sts, w_mul_sts;
    logic [lps_pkg::MUL_W-1:0]  w_mcand, w_mplier;
    logic [63:0]                w_prod;

    // Combinational datapath terms
    logic [23:0] w_raw24, w_cal;
    logic        w_cfg_wr;
    logic        w_load_out;
    logic [12:0] w_err, w_err_mag;
    logic [32:0] w_isum;
    logic [31:0] w_int_next, w_int_mag;
    logic [13:0] w_deriv_mag;
    logic [63:0] w_term;
    logic        w_term_neg;
    logic [27:0] w_tsum;
    logic [23:0] w_tsat;

    // Configuration write and read
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= 32'd16777216;
            r_ki         <= 32'd1677722;
            r_kd         <= 32'd167772;
            r_level_goal <= 11'd40;
            r_level_ref  <= 11'd49;
            r_out_max    <= 31'd5033;
            r_step_base  <= 23'd2403000;
            r_step_gain  <= 20'd160000;
        end else if (w_cfg_wr) begin
            unique case (lps_pkg::t_reg_idx'(paddr[4:2]))
                lps_pkg::REG_KP:         r_kp         <= pwdata;
                lps_pkg::REG_KI:         r_ki         <= pwdata;
                lps_pkg::REG_KD:         r_kd         <= pwdata;
                lps_pkg::REG_LEVEL_GOAL: r_level_goal <= pwdata[10:0];
                lps_pkg::REG_LEVEL_REF:  r_level_ref  <= pwdata[10:0];
                lps_pkg::REG_OUT_MAX:    r_out_max    <= pwdata[30:0];
                lps_pkg::REG_STEP_BASE:  r_step_base  <= pwdata[22:0];
                lps_pkg::REG_STEP_GAIN:  r_step_gain  <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (lps_pkg::t_reg_idx'(paddr[4:2]))
            lps_pkg::REG_KP:         prdata = r_kp;
            lps_pkg::REG_KI:         prdata = r_ki;
            lps_pkg::REG_KD:         prdata = r_kd;
            lps_pkg::REG_LEVEL_GOAL: prdata = {21'd0, r_level_goal};
            lps_pkg::REG_LEVEL_REF:  prdata = {21'd0, r_level_ref};
            lps_pkg::REG_OUT_MAX:    prdata = {1'b0, r_out_max};
            lps_pkg::REG_STEP_BASE:  prdata = {9'd0, r_step_base};
            lps_pkg::REG_STEP_GAIN:  prdata = {12'd0, r_step_gain};
            default:                 prdata = '0;
        endcase
    end

    // Shared serial units
    lps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_quo      (w_quo)
    );

    lps_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_sts    (w_mul_sts),
        .o_prod   (w_prod)
    );

    // Calibration: raw * 10000 - 4393 as shifts and adds
    assign w_raw24 = {13'd0, r_raw};
    assign w_cal   = (w_raw24 << 13) + (w_raw24 << 10) + (w_raw24 << 9)
                   + (w_raw24 << 8) + (w_raw24 << 4) - lps_pkg::CAL_OFFSET;

    // PID error terms
    assign w_err      = {2'b00, r_level_goal} - {r_level[11], r_level};
    assign w_isum     = {r_int[31], r_int} + {{20{w_err[12]}}, w_err};
    assign w_int_next = (w_isum[32] != w_isum[31])
                      ? (w_isum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : w_isum[31:0];
    assign w_err_mag   = r_err[12] ? (~r_err + 1'b1) : r_err;
    assign w_int_mag   = r_int[31] ? (~r_int + 1'b1) : r_int;
    assign w_deriv_mag = r_deriv[13] ? (~r_deriv + 1'b1) : r_deriv;

    // Operand selection for the shared units
    always_comb begin
        w_dividend = {3'd0, r_us17};
        w_divisor  = lps_pkg::US_DIVISOR;
        w_mcand    = r_kp;
        w_mplier   = {19'd0, w_err_mag};
        w_term_neg = r_err[12];
        unique case (r_state)
            lps_pkg::ST_DIST: begin
                w_dividend = w_cal;
                w_divisor  = lps_pkg::CAL_DIVISOR;
            end
            lps_pkg::ST_AVG: begin
                w_dividend = lps_pkg::DIV_W'(r_sum);
                w_divisor  = lps_pkg::DSR_W'(AVERAGE_DEPTH);
            end
            lps_pkg::ST_KI: begin
                w_mcand    = r_ki;
                w_mplier   = w_int_mag;
                w_term_neg = r_int[31];
            end
            lps_pkg::ST_KD: begin
                w_mcand    = r_kd;
                w_mplier   = {18'd0, w_deriv_mag};
                w_term_neg = r_deriv[13];
            end
            lps_pkg::ST_STEP: begin
                w_mcand    = {1'b0, r_pid};
                w_mplier   = {12'd0, r_step_gain};
                w_term_neg = 1'b0;
            end
            default: ;
        endcase
    end

    // Limit the integral term, pass the others as they are
    assign w_term = (r_state == lps_pkg::ST_KI && w_prod > lps_pkg::KI_LIMIT)
                  ? lps_pkg::KI_LIMIT : w_prod;

    // Step mapping with saturation
    assign w_tsum = {5'd0, r_step_base} + {1'b0, w_prod[50:24]};
    assign w_tsat = (w_tsum[27:24] != 4'd0) ? lps_pkg::TOP24 : w_tsum[23:0];

    assign w_load_out = (r_state == lps_pkg::ST_OUT) && (!r_mvalid || m_tready);

    // Next state and unit starts
    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        unique case (r_state)
            lps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = lps_pkg::ST_RAW;
                end
            end
            lps_pkg::ST_RAW, lps_pkg::ST_DIST, lps_pkg::ST_AVG: begin
                if (!r_issued) begin
                    w_div_start = 1'b1;
                    n_issued    = 1'b1;
                end else if (w_div_sts.done) begin
                    n_issued = 1'b0;
                    priority if (r_state == lps_pkg::ST_RAW) begin
                        n_state = (w_quo == '0) ? lps_pkg::ST_SUM : lps_pkg::ST_DIST;
                    end else if (r_state == lps_pkg::ST_DIST) begin
                        n_state = lps_pkg::ST_SUM;
                    end else begin
                        n_state = lps_pkg::ST_PID;
                    end
                end
            end
            lps_pkg::ST_SUM:   n_state = lps_pkg::ST_AVG;
            lps_pkg::ST_PID:   n_state = lps_pkg::ST_KP;
            lps_pkg::ST_KP, lps_pkg::ST_KI, lps_pkg::ST_KD, lps_pkg::ST_STEP: begin
                if (!r_issued) begin
                    w_mul_start = 1'b1;
                    n_issued    = 1'b1;
                end else if (w_mul_sts.done) begin
                    n_issued = 1'b0;
                    unique case (r_state)
                        lps_pkg::ST_KP: n_state = lps_pkg::ST_KI;
                        lps_pkg::ST_KI: n_state = lps_pkg::ST_KD;
                        lps_pkg::ST_KD: n_state = lps_pkg::ST_CLAMP;
                        default:        n_state = lps_pkg::ST_OUT;
                    endcase
                end
            end
            lps_pkg::ST_CLAMP: n_state = lps_pkg::ST_STEP;
            lps_pkg::ST_OUT: begin
                if (w_load_out) begin
                    n_state = lps_pkg::ST_IDLE;
                end
            end
            default: n_state = lps_pkg::ST_IDLE;
        endcase
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lps_pkg::ST_IDLE;
            r_issued <= 1'b0;
            r_ptr    <= '0;
            r_sum    <= '0;
            r_int    <= '0;
            r_prev   <= '0;
            r_pos    <= '0;
            r_mvalid <= 1'b0;
            for (int i = 0; i < AVERAGE_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            // Advance the moving average window
            if (r_state == lps_pkg::ST_SUM) begin
                r_sum         <= r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(r_dist);
                r_ring[r_ptr] <= r_dist;
                r_ptr <= (r_ptr == PTR_W'(AVERAGE_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
            end
            // Update the integral and derivative history
            if (r_state == lps_pkg::ST_PID) begin
                r_int  <= w_int_next;
                r_prev <= w_err;
            end
            // Hand the result to the output register, drop it once taken
            if (w_load_out) begin
                r_mvalid <= 1'b1;
                r_pos    <= r_target;
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == lps_pkg::ST_IDLE && s_tvalid) begin
            r_us17 <= {s_tdata, 4'd0} + {5'd0, s_tdata};
        end
        if (r_state == lps_pkg::ST_RAW && r_issued && w_div_sts.done) begin
            r_raw  <= w_quo[10:0];
            r_dist <= '0;
        end
        if (r_state == lps_pkg::ST_DIST && r_issued && w_div_sts.done) begin
            r_dist <= w_quo[10:0];
        end
        if (r_state == lps_pkg::ST_AVG && r_issued && w_div_sts.done) begin
            r_level <= {1'b0, r_level_ref} - {1'b0, w_quo[10:0]};
        end
        if (r_state == lps_pkg::ST_PID) begin
            r_err   <= w_err;
            r_deriv <= {w_err[12], w_err} - {r_prev[12], r_prev};
            r_acc   <= '0;
        end
        if ((r_state == lps_pkg::ST_KP || r_state == lps_pkg::ST_KI
             || r_state == lps_pkg::ST_KD) && r_issued && w_mul_sts.done) begin
            r_acc <= w_term_neg ? (r_acc - w_term) : (r_acc + w_term);
        end
        // Clamp the controller output to [0, out_max]
        if (r_state == lps_pkg::ST_CLAMP) begin
            priority if (r_acc[63]) begin
                r_pid <= '0;
            end else if (r_acc > {33'd0, r_out_max}) begin
                r_pid <= r_out_max;
            end else begin
                r_pid <= r_acc[30:0];
            end
        end
        if (r_state == lps_pkg::ST_STEP && r_issued && w_mul_sts.done) begin
            r_target <= w_tsat;
        end
        if (w_load_out) begin
            r_o_level  <= r_level;
            r_o_pid    <= r_pid;
            r_o_target <= r_target;
            r_o_dir    <= r_target > r_pos;
            r_o_count  <= (r_target > r_pos) ? (r_target - r_pos) : (r_pos - r_target);
        end
    end

    assign s_tready = (r_state == lps_pkg::ST_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = {4'd0, r_o_dir, r_o_count, r_o_target, r_o_pid, r_o_level};

    `LPS_ASSERT(a_ptr_range, r_ptr <= PTR_W'(AVERAGE_DEPTH - 1))
    `LPS_ASSERT_IMP(a_dir_moves, r_mvalid && r_o_dir, r_o_count != 24'd0)
    `LPS_ASSERT_IMP(a_mul_free, w_mul_start, !w_mul_sts.busy && !w_div_sts.busy)
    `LPS_ASSERT_IMP(a_div_free, w_div_start, !w_div_sts.busy && !w_mul_sts.busy)

endmodule
